// ===== src/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg: shared types for the bitmap frame allocator
// Opcodes, status codes, the command passed from the front end to the
// back end through the command queue, and the back-to-front control group.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ADDR_W     = 48;  // byte addresses and region lengths
  localparam int CNT_W      = 17;  // frame_limit register and used_count
  localparam int FRAME_W    = 21;  // frame indices, covers the largest frame count
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RESERVE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_BEYOND   = 2'd2
  } status_t;

  // Free block is carried as a one-frame clear.
  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [FRAME_W-1:0]   start;   // first frame of the run
    logic [FRAME_W-1:0]   stop;    // one past the last frame, clipped to the limit
    logic [FRAME_W-1:0]   count;   // frames in the run, zero when nothing changes
    status_t              status;
  } bfa_cmd_t;

  typedef struct packed {
    logic                 fill_busy;
    logic [FRAME_W-1:0]   limit;
  } bfa_ctl_t;

endpackage

// ===== src/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bfa_front.sv =====
// ----------------------------------------------------------------------------
// bfa_front: request intake and classification
// Registers a request, turns byte address and length into a clipped frame
// run against the frame limit, and hands a command to the queue.
// ----------------------------------------------------------------------------
module bfa_front
  import bfa_pkg::*;
#(
  parameter int BLK_SHIFT = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  opcode_t           in_op,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [ADDR_W-1:0] in_bytes,
  input  bfa_ctl_t          ctl,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output bfa_cmd_t          cmd
);

  // intake register
  logic              f1_vld_r, f1_vld_nxt;
  opcode_t           f1_op_r;
  logic [ADDR_W-1:0] f1_addr_r;
  logic [ADDR_W-1:0] f1_bytes_r;

  // classified stage
  logic               sa_vld_r, sa_vld_nxt;
  cmd_kind_t          sa_kind_r, sa_kind_nxt;
  logic [FRAME_W-1:0] sa_start_r, sa_start_nxt;
  logic [FRAME_W-1:0] sa_stop_r, sa_stop_nxt;
  logic               sa_empty_r, sa_empty_nxt;
  status_t            sa_status_r, sa_status_nxt;

  logic              sa_adv;
  logic              f1_take;
  logic [ADDR_W-1:0] start_full;
  logic [ADDR_W-1:0] n_full;
  logic [ADDR_W:0]   end_full;
  logic [ADDR_W:0]   lim_ext;
  logic              beyond;
  logic              start_ge;

  assign sa_adv   = !sa_vld_r || cmd_ready;
  assign f1_take  = f1_vld_r && sa_adv;
  assign in_ready = !ctl.fill_busy && (!f1_vld_r || sa_adv);

  always_comb begin
    start_full = f1_addr_r >> BLK_SHIFT;
    unique case (f1_op_r) inside
      OP_ALLOC:               n_full = '0;
      OP_FREE:                n_full = ADDR_W'(1);
      OP_RELEASE, OP_RESERVE: n_full = f1_bytes_r >> BLK_SHIFT;
      default:                n_full = '0;
    endcase
    end_full = {1'b0, start_full} + {1'b0, n_full};
    lim_ext  = (ADDR_W + 1)'(ctl.limit);
    beyond   = end_full > lim_ext;
    start_ge = {1'b0, start_full} >= lim_ext;

    unique case (f1_op_r) inside
      OP_ALLOC:           sa_kind_nxt = CMD_ALLOC;
      OP_FREE, OP_RELEASE: sa_kind_nxt = CMD_CLEAR;
      OP_RESERVE:         sa_kind_nxt = CMD_SET;
      default:            sa_kind_nxt = CMD_ALLOC;
    endcase
    sa_start_nxt  = start_full[FRAME_W-1:0];
    sa_stop_nxt   = beyond ? ctl.limit : end_full[FRAME_W-1:0];
    sa_empty_nxt  = start_ge || (f1_op_r == OP_ALLOC);
    sa_status_nxt = ((n_full != '0) && beyond) ? ST_BEYOND : ST_OK;

    f1_vld_nxt = f1_vld_r;
    if (f1_take) begin
      f1_vld_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      f1_vld_nxt = 1'b1;
    end

    sa_vld_nxt = sa_vld_r;
    if (sa_adv) begin
      sa_vld_nxt = f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      sa_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= f1_vld_nxt;
      sa_vld_r <= sa_vld_nxt;
    end
    if (in_valid && in_ready) begin
      f1_op_r    <= in_op;
      f1_addr_r  <= in_addr;
      f1_bytes_r <= in_bytes;
    end
    if (f1_take) begin
      sa_kind_r   <= sa_kind_nxt;
      sa_start_r  <= sa_start_nxt;
      sa_stop_r   <= sa_stop_nxt;
      sa_empty_r  <= sa_empty_nxt;
      sa_status_r <= sa_status_nxt;
    end
  end

  // stop never lies below start when the run is not empty
  always_comb begin
    cmd.kind   = sa_kind_r;
    cmd.start  = sa_start_r;
    cmd.stop   = sa_stop_r;
    cmd.count  = sa_empty_r ? '0 : (sa_stop_r - sa_start_r);
    cmd.status = sa_status_r;
  end

  assign cmd_valid = sa_vld_r;

endmodule

// ===== src/bfa_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// bfa_cmd_fifo: two-entry command queue
// Decouples request classification from bitmap execution.
// ----------------------------------------------------------------------------
module bfa_cmd_fifo
  import bfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bfa_cmd_t in_cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output bfa_cmd_t out_cmd
);

  bfa_cmd_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_cmd   = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ===== src/bfa_back.sv =====
// ----------------------------------------------------------------------------
// bfa_back: bitmap execution engine
// Owns the frame bitmap RAM, the used-frame count and the frame limit.
// Runs the fill pass, the first-fit word scan and the word-wise region walk,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module bfa_back
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES = 65536,
  parameter int WORD_BITS  = 64,
  parameter int BLK_SHIFT  = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  output bfa_ctl_t          ctl,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  bfa_cmd_t          cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_addr,
  output status_t           out_status,
  output logic [CNT_W-1:0]  out_used
);

  localparam int WB_SHIFT   = $clog2(WORD_BITS);
  localparam int WB_W       = WB_SHIFT;
  localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WI_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam logic [WORD_BITS-1:0] ONES     = {WORD_BITS{1'b1}};
  localparam logic [FRAME_W-1:0]   MAX_LIM  = FRAME_W'(MAX_FRAMES);
  localparam logic [WI_W-1:0]      LAST_IDX = WI_W'(WORD_COUNT - 1);

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [FRAME_W-1:0] limit_r, limit_nxt;
  logic [FRAME_W-1:0] used_r, used_nxt;
  logic [WI_W-1:0]    fill_idx_r, fill_idx_nxt;
  logic [WI_W:0]      scan_idx_r, scan_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [WI_W-1:0]    chk_idx_r, chk_idx_nxt;
  cmd_kind_t          kind_r, kind_nxt;
  logic [WI_W-1:0]    first_w_r, first_w_nxt;
  logic [WI_W-1:0]    last_w_r, last_w_nxt;
  logic [WB_W-1:0]    first_b_r, first_b_nxt;
  logic [WB_W-1:0]    last_b_r, last_b_nxt;
  logic [WI_W:0]      rd_w_r, rd_w_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [WI_W-1:0]    pend_w_r, pend_w_nxt;
  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   out_used_r, out_used_nxt;

  logic                 ram_we;
  logic [WI_W-1:0]      ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WI_W-1:0]      ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [FRAME_W-1:0]   words;
  logic [FRAME_W-1:0]   cfg_lim;
  logic [FRAME_W-1:0]   last_frame;
  logic [FRAME_W:0]     used_sum;
  logic                 issue;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] low_bit;
  logic [WB_W-1:0]      low_idx;
  logic [63:0]          frame;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready     = 1'b1;
  assign cmd_ready     = (state_r == S_IDLE);
  assign ctl.fill_busy = (state_r == S_FILL);
  assign ctl.limit     = limit_r;
  assign out_valid     = out_vld_r;
  assign out_addr      = out_addr_r;
  assign out_status    = out_status_r;
  assign out_used      = out_used_r;

  // only whole words below the limit take part in allocation
  assign words      = limit_r >> WB_SHIFT;
  assign cfg_lim    = (FRAME_W'(cfg_data) > MAX_LIM) ? MAX_LIM : FRAME_W'(cfg_data);
  assign last_frame = cmd.stop - FRAME_W'(1);
  assign used_sum   = {1'b0, used_r} + {1'b0, cmd.count};

  // lowest free bit of the word just read
  always_comb begin
    free_bits = ~ram_rdata;
    low_bit   = free_bits & (~free_bits + WORD_BITS'(1));
    low_idx   = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low_bit[j]) begin
        low_idx = low_idx | WB_W'(j);
      end
    end
    frame = (64'(chk_idx_r) << WB_SHIFT) | 64'(low_idx);
  end

  // bits of the region inside the word being written
  always_comb begin
    lo_mask = (pend_w_r == first_w_r) ? (ONES << first_b_r) : ONES;
    hi_mask = (pend_w_r == last_w_r) ? (ONES >> (WB_W'(WORD_BITS - 1) - last_b_r)) : ONES;
  end

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    used_nxt       = used_r;
    fill_idx_nxt   = fill_idx_r;
    scan_idx_nxt   = scan_idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    kind_nxt       = kind_r;
    first_w_nxt    = first_w_r;
    last_w_nxt     = last_w_r;
    first_b_nxt    = first_b_r;
    last_b_nxt     = last_b_r;
    rd_w_nxt       = rd_w_r;
    pend_vld_nxt   = 1'b0;
    pend_w_nxt     = pend_w_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_vld_nxt    = out_vld_r && !out_ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_used_nxt   = out_used_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = ONES;
    ram_raddr      = '0;
    issue          = 1'b0;

    unique case (state_r)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_idx_r;
        ram_wdata = ONES;
        if (fill_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          fill_idx_nxt = fill_idx_r + WI_W'(1);
        end
      end

      S_IDLE: begin
        if (cmd_valid) begin
          kind_nxt     = cmd.kind;
          res_addr_nxt = '0;
          unique case (cmd.kind)
            CMD_ALLOC: begin
              if ((used_r >= limit_r) || (words == '0)) begin
                res_status_nxt = ST_NO_FRAME;
                state_nxt      = S_DONE;
              end else begin
                scan_idx_nxt = '0;
                state_nxt    = S_SCAN;
              end
            end
            CMD_CLEAR: begin
              used_nxt       = (used_r > cmd.count) ? (used_r - cmd.count) : '0;
              res_status_nxt = cmd.status;
            end
            CMD_SET: begin
              used_nxt = (used_sum > {1'b0, limit_r}) ? limit_r : used_sum[FRAME_W-1:0];
              res_status_nxt = cmd.status;
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
          if (cmd.kind != CMD_ALLOC) begin
            first_w_nxt = WI_W'(cmd.start >> WB_SHIFT);
            last_w_nxt  = WI_W'(last_frame >> WB_SHIFT);
            first_b_nxt = cmd.start[WB_W-1:0];
            last_b_nxt  = last_frame[WB_W-1:0];
            rd_w_nxt    = {1'b0, WI_W'(cmd.start >> WB_SHIFT)};
            state_nxt   = (cmd.count == '0) ? S_DONE : S_WALK;
          end
        end
      end

      S_SCAN: begin
        // read one word a cycle, check it the cycle after
        issue        = FRAME_W'(scan_idx_r) < words;
        ram_raddr    = scan_idx_r[WI_W-1:0];
        chk_vld_nxt  = issue;
        chk_idx_nxt  = scan_idx_r[WI_W-1:0];
        scan_idx_nxt = issue ? (scan_idx_r + (WI_W + 1)'(1)) : scan_idx_r;
        if (chk_vld_r && (free_bits != '0)) begin
          ram_we         = 1'b1;
          ram_waddr      = chk_idx_r;
          ram_wdata      = ram_rdata | low_bit;
          used_nxt       = used_r + FRAME_W'(1);
          res_addr_nxt   = ADDR_W'(frame << BLK_SHIFT);
          res_status_nxt = ST_OK;
          chk_vld_nxt    = 1'b0;
          state_nxt      = S_DONE;
        end else if (!chk_vld_r && !issue) begin
          res_status_nxt = ST_NO_FRAME;
          state_nxt      = S_DONE;
        end
      end

      S_WALK: begin
        // read the next word while the previous one is written back
        issue        = rd_w_r <= {1'b0, last_w_r};
        ram_raddr    = rd_w_r[WI_W-1:0];
        pend_vld_nxt = issue;
        pend_w_nxt   = rd_w_r[WI_W-1:0];
        rd_w_nxt     = issue ? (rd_w_r + (WI_W + 1)'(1)) : rd_w_r;
        if (pend_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_w_r;
          ram_wdata = (kind_r == CMD_SET) ? (ram_rdata | (lo_mask & hi_mask))
                                          : (ram_rdata & ~(lo_mask & hi_mask));
        end else if (!issue) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_r || out_ready) begin
          out_vld_nxt    = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_used_nxt   = used_r[CNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_FILL;
      end
    endcase

    // a new limit restarts the allocator with every frame used
    if (cfg_valid) begin
      limit_nxt    = cfg_lim;
      used_nxt     = cfg_lim;
      fill_idx_nxt = '0;
      state_nxt    = S_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_FILL;
      limit_r    <= MAX_LIM;
      used_r     <= MAX_LIM;
      fill_idx_r <= '0;
      chk_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      limit_r    <= limit_nxt;
      used_r     <= used_nxt;
      fill_idx_r <= fill_idx_nxt;
      chk_vld_r  <= chk_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    scan_idx_r   <= scan_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    kind_r       <= kind_nxt;
    first_w_r    <= first_w_nxt;
    last_w_r     <= last_w_nxt;
    first_b_r    <= first_b_nxt;
    last_b_r     <= last_b_nxt;
    rd_w_r       <= rd_w_nxt;
    pend_w_r     <= pend_w_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
  end

`ifndef SYNTH
  a_used_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= limit_r)
    else $error("used frame count above frame limit");

  a_scan_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (({1'b0, chk_idx_r} + (WI_W + 1)'(1)) == scan_idx_r))
    else $error("checked word is not the one read last");

  a_walk_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> ((pend_w_r >= first_w_r) && (pend_w_r <= last_w_r)))
    else $error("region write outside its word range");

  a_cfg_refills: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> ((state_r == S_FILL) && (fill_idx_r == '0) && (used_r == limit_r)))
    else $error("limit write did not restart the fill pass");
`endif

endmodule

// ===== src/bitmap_frame_allocator.sv =====
// Flow: intake and classification registers, the queue, then the engine with one
//   RAM read a cycle; a free or region change walks the touched words, an allocate
//   scans words to a hit or a miss, and an empty run or an allocate refused at once
//   goes straight to the result. Occupancy: one request in the engine; up to four
//   more wait in intake and queue. Reset: every frame used and the count at the
//   limit; a fill pass over every bitmap word follows reset and each limit write.
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: first-fit bitmap page-frame allocator
// Stream front end classifies requests into frame runs, a command queue feeds
// the bitmap engine. BLOCK_BYTES and WORD_BITS must be powers of two; the block does not check this.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES  = 65536,
  parameter int BLOCK_BYTES = 4096,
  parameter int WORD_BITS   = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // address[47:0], region_bytes[95:48]
  input  logic [1:0]            in_tuser,   // opcode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // block_address[47:0], used_count[64:48], zero
  output logic [1:0]            out_tuser,  // status[1:0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data    // frame_limit
);

  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);

  bfa_ctl_t          ctl;
  logic              fq_valid;
  logic              fq_ready;
  bfa_cmd_t          fq_cmd;
  logic              qb_valid;
  logic              qb_ready;
  bfa_cmd_t          qb_cmd;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;
  logic [CNT_W-1:0]  res_used;
  opcode_t           in_op;

  assign in_op = opcode_t'(in_tuser);

  bfa_front #(
    .BLK_SHIFT (BLK_SHIFT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_op),
    .in_addr   (in_tdata[ADDR_W-1:0]),
    .in_bytes  (in_tdata[2*ADDR_W-1:ADDR_W]),
    .ctl       (ctl),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  bfa_cmd_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_cmd    (fq_cmd),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_cmd   (qb_cmd)
  );

  bfa_back #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS),
    .BLK_SHIFT  (BLK_SHIFT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .ctl        (ctl),
    .cmd_valid  (qb_valid),
    .cmd_ready  (qb_ready),
    .cmd        (qb_cmd),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_addr   (res_addr),
    .out_status (res_status),
    .out_used   (res_used)
  );

  assign out_tdata = {{(OUT_DATA_W - ADDR_W - CNT_W){1'b0}}, res_used, res_addr};
  assign out_tuser = res_status;

endmodule
